// ----- hw/rtl/slp_pkg.sv -----
// Shared types and constants for the slew-limited thruster PWM core.
// No dependencies; used by slp_limiter, slp_pulse_map and the top level.
package slp_pkg;

   localparam int CMD_W       = 16;
   localparam int PULSE_CFG_W = 16;
   localparam int STEP_W      = 15;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 56;

   typedef enum logic [1:0] {
      ACT_SET     = 2'd0,
      ACT_TICK    = 2'd1,
      ACT_ENABLE  = 2'd2,
      ACT_DISABLE = 2'd3
   } action_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODE_PURE      = 3'd0,
      CSR_PULSE_MIN      = 3'd1,
      CSR_PULSE_MAX      = 3'd2,
      CSR_PULSE_CENTER   = 3'd3,
      CSR_STEP_SIZE      = 3'd4,
      CSR_SLEW_THRESHOLD = 3'd5
   } csr_index_type;

   localparam logic [PULSE_CFG_W-1:0] RST_PULSE_MIN    = 16'd1100;
   localparam logic [PULSE_CFG_W-1:0] RST_PULSE_MAX    = 16'd1900;
   localparam logic [PULSE_CFG_W-1:0] RST_PULSE_CENTER = 16'd1500;
   localparam logic [STEP_W-1:0]      RST_STEP_SIZE    = 15'd164;
   localparam logic [STEP_W-1:0]      RST_SLEW_THR     = 15'd819;

endpackage

// ----- hw/rtl/slew_limited_thruster_pwm_core.sv -----
// Top level of the slew-limited thruster PWM core: registers, handshakes, state.
// Depends on slp_pkg, slp_limiter and slp_pulse_map.
//
// Takes one command item per clock unless the result side stalls, and returns
// exactly one result per item. An accepted item waits in an input register
// until the result register is taken or empty; then the limiter, the single
// multiplier of the pulse mapping and the rounding update the state and load
// the result register. Throughput is one item per cycle unless the result side
// stalls, set by that state update loop. Input is accepted while either
// register is empty or the result is taken. Configuration writes take effect
// at once and are meant to be made while no item is in flight.
module slew_limited_thruster_pwm_core #(
   parameter int VALUE_FRAC_BITS = 14,
   parameter int PULSE_BITS      = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [slp_pkg::REQ_TDATA_W-1:0]    req_tdata,  // [15:0] command_value
   input  logic [1:0]                         req_tuser,  // [1:0] action
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [15:0] drive_level, [16] output_on, [32:17] present_value,
   // [48:33] stored_pulse, [55:49] zero
   output logic [slp_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                               csr_we,
   input  logic [slp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [slp_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int VAL_W = VALUE_FRAC_BITS + 2;
   localparam int PW    = (PULSE_BITS > 16) ? PULSE_BITS : 16;
   localparam int WVW   = (VAL_W > 16) ? VAL_W : 16;
   localparam logic signed [VAL_W-1:0] ONE_V = VAL_W'(1) << VALUE_FRAC_BITS;

   // configuration
   logic                                mode_pure_ff;
   logic [slp_pkg::PULSE_CFG_W-1:0]     pulse_min_ff, pulse_max_ff, pulse_center_ff;
   logic [slp_pkg::STEP_W-1:0]          step_size_ff, slew_thr_ff;

   // input register
   logic                                in_vld_ff;
   slp_pkg::action_type                 in_action_ff;
   logic signed [slp_pkg::CMD_W-1:0]    in_cmd_ff;

   // state
   logic signed [slp_pkg::CMD_W-1:0]    target_ff, target_in;
   logic signed [VAL_W-1:0]             present_ff, present_in;
   logic [PW-1:0]                       pulse_ff, pulse_in;
   logic [PW-1:0]                       level_ff, level_in;
   logic                                enabled_ff, enabled_in;
   logic                                halted_ff, halted_in;

   // result register
   logic                                rsp_vld_ff;
   logic [slp_pkg::RSP_TDATA_W-1:0]     rsp_data_ff, rsp_data_in;

   logic                                advance, fire, upd;
   logic signed [VAL_W-1:0]             new_value;
   logic [PW-1:0]                       new_pulse, en_pulse;
   logic signed [WVW-1:0]               present_wide;

   assign advance    = !rsp_vld_ff || rsp_tready;
   assign req_tready = !in_vld_ff || advance;
   assign fire       = in_vld_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_pure_ff    <= 1'b0;
         pulse_min_ff    <= slp_pkg::RST_PULSE_MIN;
         pulse_max_ff    <= slp_pkg::RST_PULSE_MAX;
         pulse_center_ff <= slp_pkg::RST_PULSE_CENTER;
         step_size_ff    <= slp_pkg::RST_STEP_SIZE;
         slew_thr_ff     <= slp_pkg::RST_SLEW_THR;
      end else if (csr_we) begin
         unique case (slp_pkg::csr_index_type'(csr_index))
            slp_pkg::CSR_MODE_PURE:      mode_pure_ff    <= csr_wdata[0];
            slp_pkg::CSR_PULSE_MIN:      pulse_min_ff    <= csr_wdata;
            slp_pkg::CSR_PULSE_MAX:      pulse_max_ff    <= csr_wdata;
            slp_pkg::CSR_PULSE_CENTER:   pulse_center_ff <= csr_wdata;
            slp_pkg::CSR_STEP_SIZE:      step_size_ff    <= csr_wdata[slp_pkg::STEP_W-1:0];
            slp_pkg::CSR_SLEW_THRESHOLD: slew_thr_ff     <= csr_wdata[slp_pkg::STEP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_action_ff <= slp_pkg::action_type'(req_tuser);
         in_cmd_ff    <= signed'(req_tdata);
      end
   end

   slp_limiter #(
      .FRAC_BITS (VALUE_FRAC_BITS)
   ) u_limiter (
      .action    (in_action_ff),
      .cmd       (in_cmd_ff),
      .mode_pure (mode_pure_ff),
      .enabled   (enabled_ff),
      .halted    (halted_ff),
      .target    (target_ff),
      .present   (present_ff),
      .step_size (step_size_ff),
      .slew_thr  (slew_thr_ff),
      .upd       (upd),
      .value     (new_value)
   );

   slp_pulse_map #(
      .FRAC_BITS  (VALUE_FRAC_BITS),
      .PULSE_BITS (PULSE_BITS)
   ) u_pulse_map (
      .value     (new_value),
      .mode_pure (mode_pure_ff),
      .pulse_min (pulse_min_ff),
      .pulse_max (pulse_max_ff),
      .pulse     (new_pulse)
   );

   assign en_pulse = mode_pure_ff ? PW'(pulse_min_ff) : PW'(pulse_center_ff);

   always_comb begin
      target_in  = target_ff;
      present_in = present_ff;
      pulse_in   = pulse_ff;
      level_in   = level_ff;
      enabled_in = enabled_ff;
      halted_in  = halted_ff;
      if (fire) begin
         case (in_action_ff)
            slp_pkg::ACT_SET: begin
               if (!mode_pure_ff) begin
                  target_in = in_cmd_ff;
               end
            end
            slp_pkg::ACT_TICK: begin
               if (!halted_ff && mode_pure_ff) begin
                  halted_in = 1'b1;
               end
            end
            slp_pkg::ACT_ENABLE: begin
               enabled_in = 1'b1;
               pulse_in   = en_pulse;
               level_in   = en_pulse;
            end
            default: begin
               enabled_in = 1'b0;
            end
         endcase
         if (upd) begin
            present_in = new_value;
            pulse_in   = new_pulse;
            if (enabled_ff) begin
               level_in = new_pulse;
            end
         end
      end
   end

   assign present_wide = WVW'(present_in);
   assign rsp_data_in  = {7'd0, pulse_in[15:0], present_wide[15:0], enabled_in, level_in[15:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff  <= '0;
         present_ff <= '0;
         pulse_ff   <= PW'(slp_pkg::RST_PULSE_CENTER);
         level_ff   <= '0;
         enabled_ff <= 1'b0;
         halted_ff  <= 1'b0;
      end else begin
         target_ff  <= target_in;
         present_ff <= present_in;
         pulse_ff   <= pulse_in;
         level_ff   <= level_in;
         enabled_ff <= enabled_in;
         halted_ff  <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (fire) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   // held item is not lost while the result side stalls
   assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !advance) |=> (in_vld_ff && $stable(in_cmd_ff)))
      else $error("input register overwritten during stall");

   // once halted, the limiter stays halted until reset
   assert property (@(posedge clock) disable iff (reset) !$fell(halted_ff))
      else $error("limiter halt released");

   // magnitude never leaves -1..+1
   assert property (@(posedge clock) disable iff (reset)
      (present_ff <= ONE_V) && (present_ff >= -ONE_V))
      else $error("present magnitude out of range");

   // driven level only moves while the output is enabled or being enabled
   assert property (@(posedge clock) disable iff (reset)
      (!enabled_ff && !(fire && in_action_ff == slp_pkg::ACT_ENABLE)) |=> $stable(level_ff))
      else $error("drive level changed while disabled");

endmodule

// ----- hw/rtl/slp_limiter.sv -----
// Next-magnitude selection: set clamping in pure mode, slew stepping on ticks otherwise.
// Depends on slp_pkg.
module slp_limiter #(
   parameter int FRAC_BITS = 14
) (
   input  slp_pkg::action_type                  action,
   input  logic signed [slp_pkg::CMD_W-1:0]     cmd,
   input  logic                                 mode_pure,
   input  logic                                 enabled,
   input  logic                                 halted,
   input  logic signed [slp_pkg::CMD_W-1:0]     target,
   input  logic signed [FRAC_BITS+1:0]          present,
   input  logic        [slp_pkg::STEP_W-1:0]    step_size,
   input  logic        [slp_pkg::STEP_W-1:0]    slew_thr,
   output logic                                 upd,
   output logic signed [FRAC_BITS+1:0]          value
);

   localparam int VAL_W = FRAC_BITS + 2;
   localparam int VW    = ((VAL_W > slp_pkg::CMD_W) ? VAL_W : slp_pkg::CMD_W) + 1;
   localparam logic signed [VW-1:0] ONE_X = VW'(1) << FRAC_BITS;

   logic signed [VW-1:0] tgt_x, pres_x, cmd_x, step_x, thr_x;
   logic signed [VW-1:0] diff, gap, stepped, cand, lo_x, clamped;
   logic                 is_set, is_tick;

   assign tgt_x  = VW'(target);
   assign pres_x = VW'(present);
   assign cmd_x  = VW'(cmd);
   assign step_x = signed'(VW'(step_size));
   assign thr_x  = signed'(VW'(slew_thr));

   assign diff    = tgt_x - pres_x;
   assign gap     = diff[VW-1] ? -diff : diff;
   assign stepped = diff[VW-1] ? pres_x - step_x : pres_x + step_x;

   assign is_set  = (action == slp_pkg::ACT_SET);
   assign is_tick = (action == slp_pkg::ACT_TICK);

   always_comb begin
      if (is_set) begin
         cand = cmd_x;
      end else if (gap > thr_x) begin
         cand = stepped;
      end else begin
         cand = tgt_x;
      end
      lo_x = mode_pure ? '0 : -ONE_X;
      if (cand < lo_x) begin
         clamped = lo_x;
      end else if (cand > ONE_X) begin
         clamped = ONE_X;
      end else begin
         clamped = cand;
      end
   end

   assign value = clamped[VAL_W-1:0];
   assign upd   = (is_set && mode_pure)
                || (is_tick && !halted && !mode_pure && enabled && (diff != '0));

endmodule

// ----- hw/rtl/slp_pulse_map.sv -----
// Magnitude to pulse width mapping: one multiply, round half away from zero,
// saturate. Depends on slp_pkg.
module slp_pulse_map #(
   parameter int FRAC_BITS  = 14,
   parameter int PULSE_BITS = 16
) (
   input  logic signed [FRAC_BITS+1:0]               value,
   input  logic                                      mode_pure,
   input  logic [slp_pkg::PULSE_CFG_W-1:0]           pulse_min,
   input  logic [slp_pkg::PULSE_CFG_W-1:0]           pulse_max,
   output logic [((PULSE_BITS > 16) ? PULSE_BITS : 16)-1:0] pulse
);

   localparam int PW  = (PULSE_BITS > 16) ? PULSE_BITS : 16;
   localparam int PRW = FRAC_BITS + 19;
   localparam int NW  = FRAC_BITS + 21;
   localparam int CW  = (NW > PULSE_BITS + 2) ? NW : PULSE_BITS + 2;
   localparam logic signed [NW-1:0] HALF_P = NW'(1) << (FRAC_BITS - 1);
   localparam logic signed [NW-1:0] HALF_T = NW'(1) << FRAC_BITS;
   localparam logic signed [CW-1:0] TOP_X  = (CW'(1) << PULSE_BITS) - CW'(1);

   logic signed [16:0]    span;
   logic signed [PRW-1:0] prod;
   logic signed [NW-1:0]  prod_x, base_x, thr_num, neg_p, neg_t;
   logic signed [NW-1:0]  rnd_p, rnd_t, q_p, q_t, min_x, p_raw;
   logic signed [CW-1:0]  p_x, p_sat;

   assign span   = signed'({1'b0, pulse_max}) - signed'({1'b0, pulse_min});
   assign prod   = value * span;
   assign prod_x = NW'(prod);
   assign base_x = signed'(NW'({1'b0, pulse_max} + {1'b0, pulse_min})) <<< FRAC_BITS;
   assign thr_num = prod_x + base_x;
   assign min_x  = signed'(NW'(pulse_min));

   assign neg_p = signed'(NW'(prod_x[NW-1]));
   assign neg_t = signed'(NW'(thr_num[NW-1]));
   assign rnd_p = prod_x + HALF_P - neg_p;
   assign rnd_t = thr_num + HALF_T - neg_t;
   assign q_p   = rnd_p >>> FRAC_BITS;
   assign q_t   = rnd_t >>> (FRAC_BITS + 1);
   assign p_raw = mode_pure ? q_p + min_x : q_t;
   assign p_x   = CW'(p_raw);

   always_comb begin
      if (p_x < 0) begin
         p_sat = '0;
      end else if (p_x > TOP_X) begin
         p_sat = TOP_X;
      end else begin
         p_sat = p_x;
      end
   end

   assign pulse = p_sat[PW-1:0];

endmodule
